[rtl/mbps_pkg.sv]
// Shared constants, types and register codes for the masked byte pattern scan.
`timescale 1ns / 1ps

package mbps_pkg;

    // Pattern and offset sizes
    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 24;
    localparam int COUNT_W     = OFFSET_BITS + 1;
    localparam int LEN_W       = 5;
    localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration port sizes
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CARE_W      = 16;

    // Region byte count at which counting stops
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << OFFSET_BITS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

    // Reset values
    localparam logic [CARE_W-1:0] CARE_MASK_RESET      = 16'hFFFF;
    localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RESET = 5'd1;

    // Configuration as seen by the scan core
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pattern;
        logic [MAX_PATTERN-1:0]      care;
        logic [LEN_W-1:0]            length;
    } cfg_t;

    // One result from the scan core
    typedef struct packed {
        logic                   valid;
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
    } result_t;

endpackage

[rtl/mbps_cfg_regs.sv]
// Configuration register file of the masked byte pattern scan.
`timescale 1ns / 1ps

module mbps_cfg_regs
    import mbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [63:0]       pattern_low_reg;
    logic [63:0]       pattern_high_reg;
    logic [CARE_W-1:0] care_mask_reg;
    logic [LEN_W-1:0]  pattern_length_reg;
    logic [127:0]      pattern_all;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= CARE_MASK_RESET;
            pattern_length_reg <= PATTERN_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata[63:0];
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata[63:0];
                REG_CARE_MASK:      care_mask_reg      <= cfg_wdata[CARE_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Split the pattern into bytes
    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            cfg.pattern[i] = pattern_all[i*8 +: 8];
        end
        cfg.care   = care_mask_reg[MAX_PATTERN-1:0];
        cfg.length = pattern_length_reg;
    end

endmodule

[rtl/mbps_scan_core.sv]
// Byte window, region count and masked compare of the pattern scan.
`timescale 1ns / 1ps

module mbps_scan_core
    import mbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    result
);

    logic [MAX_PATTERN-1:0][7:0] window_reg, window_next;
    logic [COUNT_W-1:0]          count_reg, count_next, count_inc;
    logic                        found_reg, found_next;
    logic [LEN_W-1:0]            eff_len;
    logic                        mismatch;
    logic                        hit;
    logic [WIN_IDX_W-1:0]        idx;

    // Clamp the length into 1..MAX_PATTERN
    always_comb
    begin
        if (cfg.length == '0)
            eff_len = LEN_W'(1);
        else if (cfg.length > LEN_W'(MAX_PATTERN))
            eff_len = LEN_W'(MAX_PATTERN);
        else
            eff_len = cfg.length;
    end

    // Shift the new byte into the window
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // Compare each cared pattern byte with its window entry
    always_comb
    begin
        mismatch = 1'b0;
        idx      = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            idx = WIN_IDX_W'(int'(eff_len) - 1 - i);
            if ((i < int'(eff_len)) && cfg.care[i] && (window_next[idx] != cfg.pattern[i]))
                mismatch = 1'b1;
        end
    end

    // Count, detect the first match and form the result
    always_comb
    begin
        count_inc     = count_reg + COUNT_W'(1);
        count_next    = count_reg;
        found_next    = found_reg;
        hit           = 1'b0;
        result.valid  = 1'b0;
        result.found  = 1'b0;
        result.offset = '0;
        if (count_reg < COUNT_LIMIT)
        begin
            count_next = count_inc;
            if (!found_reg && (count_inc >= COUNT_W'(eff_len)) && !mismatch)
                hit = 1'b1;
        end
        if (hit)
        begin
            found_next    = 1'b1;
            result.valid  = 1'b1;
            result.found  = 1'b1;
            result.offset = OFFSET_BITS'(count_inc - COUNT_W'(eff_len));
        end
        else if (last_byte && !found_reg)
        begin
            result.valid = 1'b1;
        end
        result.valid = result.valid & fire;
        if (last_byte)
        begin
            count_next = '0;
            found_next = 1'b0;
        end
    end

    // Hold scan state, advance on each processed item, clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            found_reg  <= 1'b0;
        end
        else if (fire)
        begin
            window_reg <= last_byte ? '0 : window_next;
            count_reg  <= count_next;
            found_reg  <= found_next;
        end
    end

endmodule

[rtl/masked_byte_pattern_scan_top.sv]
// Top level of the masked byte pattern scan: input stage, scan core, result register.
//
//  Channel  Direction  Payload                               Accepted when
//  s_*      in         tdata[7:0] data_byte, tlast last_byte s_tvalid && s_tready
//  m_*      out        tdata[23:0] match_offset, tuser found m_tvalid && m_tready
//  cfg_*    in         cfg_wdata by cfg_index                cfg_we
//
// One item per cycle while results are taken. An accepted item waits in the input
// register until the result register is free, is compared against the window in one
// pass, and its result, if any, lands in the result register that drives m_tvalid.
// Reset clears the window, count, found flag and both valid flags.
// A stalled result holds the input stage; s_tready stays high while the
// result register is empty or being taken.
`timescale 1ns / 1ps

module masked_byte_pattern_scan_top
    import mbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte
    // Result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OFFSET_BITS-1:0] m_tdata,   // [23:0] match_offset
    output logic                   m_tuser,   // [0] match_found
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t                   cfg;
    result_t                result;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic                   out_free;
    logic                   fire;

    mbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Process the held item when the result register can take its result
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    mbps_scan_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    // Input register: load on accept, drop when processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register: load a new result, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && result.valid)
        begin
            out_found_reg  <= result.found;
            out_offset_reg <= result.offset;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_found_reg;

endmodule
